// ===== hdl/dns_name_decompressor_unit_defines.svh =====
// assertion macros for the name decompressor
`ifndef DNS_NAME_DECOMPRESSOR_UNIT_DEFINES_SVH
`define DNS_NAME_DECOMPRESSOR_UNIT_DEFINES_SVH

// check that an implication holds on every clock edge outside reset
`define DND_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// check that a condition never holds outside reset
`define DND_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// ===== hdl/dnd_pkg.sv =====
package dnd_pkg;

	localparam int MSG_DEPTH_DEF = 512;
	localparam int NAME_MAX_DEF  = 256;

	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_APPEND = 2'd1;
	localparam logic [1:0] MODE_DECOMP = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_PAST_END = 3'd1;
	localparam logic [2:0] ST_BAD_TYPE = 3'd2;
	localparam logic [2:0] ST_TOO_LONG = 3'd3;
	localparam logic [2:0] ST_HOPS     = 3'd4;

	localparam logic [7:0] PTR_MARK = 8'd192;
	localparam logic [7:0] BAD_TYPE = 8'd64;
	localparam logic [7:0] HOPS_RESET = 8'd16;

	// datapath commands from the controller
	typedef struct packed {
		logic clear;       // message length to zero
		logic append;      // store input byte
		logic load_pos;    // position from start offset
		logic rd;          // read message at position, position advances
		logic take_len;    // latch read byte as length, write to name buffer
		logic take_ptr_hi; // latch read byte as pointer high
		logic jump;        // position from pointer, count hop
		logic copy;        // write read byte to name buffer, label count down
		logic term;        // write zero to name buffer
		logic out_start;   // reset output cursor
		logic out_rd;      // read one name byte for output word
		logic out_load;    // clear output word
	} dnd_cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic past_end;    // position at or beyond length
		logic is_ptr;      // latched byte is a pointer
		logic is_zero;
		logic is_bad;
		logic too_long_lbl;
		logic too_long_end;
		logic hops_over;   // next hop exceeds the limit
		logic lbl_done;    // label count zero
		logic out_word_full;
		logic out_rd_full; // eight reads issued for the current word
		logic out_end;     // all name bytes read out
	} dnd_sts_t;

endpackage

// ===== hdl/dnd_stream_if.sv =====
interface dnd_stream_if #(
	parameter int WIDTH = 8
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/dnd_datapath.sv =====
module dnd_datapath #(
	parameter int MSG_DEPTH = dnd_pkg::MSG_DEPTH_DEF,
	parameter int NAME_MAX  = dnd_pkg::NAME_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dnd_pkg::dnd_cmd_t cmd,
	input  logic [7:0]        in_byte,
	input  logic [13:0]       in_offset,
	input  logic [7:0]        max_hops,
	output dnd_pkg::dnd_sts_t sts,
	output logic [63:0]       word,
	output logic [3:0]        word_cnt
);
	localparam int AW = $clog2(MSG_DEPTH);
	localparam int LW = $clog2(MSG_DEPTH + 1);
	localparam int NW = $clog2(NAME_MAX);
	localparam int SW = NW + 1;

	logic [7:0]    msg_mem [MSG_DEPTH];
	logic [7:0]    name_mem [NAME_MAX];
	logic [LW-1:0] len_q;
	logic [13:0]   pos_q;
	logic [7:0]    rd_byte_q;
	logic [7:0]    lbl_q;
	logic [5:0]    ptr_hi_q;
	logic [7:0]    hops_q;
	logic [SW-1:0] size_q;
	logic [SW-1:0] opos_q;
	logic [7:0]    name_rd_q;
	logic [63:0]   word_q;
	logic [3:0]    cnt_q;
	logic          name_rd_pend_q;

	// message length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd.clear) begin
			len_q <= '0;
		end else if (cmd.append && (len_q < LW'(MSG_DEPTH))) begin
			len_q <= len_q + 1'b1;
		end
	end

	// message memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.append && (len_q < LW'(MSG_DEPTH)))
			msg_mem[len_q[AW-1:0]] <= in_byte;
		if (cmd.rd)
			rd_byte_q <= msg_mem[pos_q[AW-1:0]];
	end

	// walk position, hop count, label count, pointer high byte, name size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			hops_q <= '0;
			lbl_q  <= '0;
			ptr_hi_q <= '0;
			size_q <= '0;
		end else begin
			if (cmd.load_pos) begin
				pos_q  <= in_offset;
				hops_q <= '0;
				size_q <= '0;
			end else if (cmd.jump) begin
				pos_q  <= {ptr_hi_q, rd_byte_q};
				hops_q <= hops_q + 1'b1;
			end else if (cmd.rd) begin
				pos_q <= pos_q + 1'b1;
			end
			if (cmd.take_ptr_hi)
				ptr_hi_q <= rd_byte_q[5:0];
			if (cmd.take_len) begin
				lbl_q  <= rd_byte_q;
				size_q <= size_q + 1'b1;
			end else if (cmd.copy) begin
				lbl_q  <= lbl_q - 1'b1;
				size_q <= size_q + 1'b1;
			end else if (cmd.term) begin
				size_q <= size_q + 1'b1;
			end
		end
	end

	// name buffer writes, registered reads for output
	always_ff @(posedge clk) begin
		if (cmd.take_len || cmd.copy || cmd.term)
			name_mem[size_q[NW-1:0]] <= cmd.term ? 8'd0 : rd_byte_q;
		if (cmd.out_rd)
			name_rd_q <= name_mem[opos_q[NW-1:0]];
	end

	// output word assembly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opos_q <= '0;
			cnt_q  <= '0;
			word_q <= '0;
			name_rd_pend_q <= 1'b0;
		end else begin
			name_rd_pend_q <= cmd.out_rd;
			if (cmd.out_start)
				opos_q <= '0;
			else if (cmd.out_rd)
				opos_q <= opos_q + 1'b1;
			if (cmd.out_load) begin
				word_q <= '0;
				cnt_q  <= '0;
			end else if (name_rd_pend_q) begin
				word_q <= word_q | ({56'd0, name_rd_q} << (6'd56 - {cnt_q[2:0], 3'd0}));
				cnt_q  <= cnt_q + 1'b1;
			end
		end
	end

	logic [SW+8:0] lbl_sum;
	assign lbl_sum = {9'd0, size_q} + {{SW{1'b0}}, 1'b0, rd_byte_q} + 1'b1;

	always_comb begin
		sts.past_end     = ({{(14 > LW ? 14 - LW : 0){1'b0}}, len_q} <= 14'(pos_q))
			|| (32'(pos_q) >= MSG_DEPTH);
		sts.is_ptr       = rd_byte_q >= dnd_pkg::PTR_MARK;
		sts.is_zero      = rd_byte_q == 8'd0;
		sts.is_bad       = rd_byte_q >= dnd_pkg::BAD_TYPE;
		sts.too_long_lbl = 32'(lbl_sum) >= NAME_MAX;
		sts.too_long_end = 32'(size_q) + 1 >= NAME_MAX;
		sts.hops_over    = hops_q >= max_hops;
		sts.lbl_done     = lbl_q == 8'd0;
		sts.out_word_full = cnt_q == 4'd8;
		// reads issued so far: bytes already merged plus the one in flight
		sts.out_rd_full  = (cnt_q + {3'd0, name_rd_pend_q}) == 4'd8;
		sts.out_end      = opos_q == size_q;
	end

	assign word     = word_q;
	assign word_cnt = cnt_q;
endmodule

// ===== hdl/dnd_ctrl.sv =====
module dnd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_mode,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_last,
	output logic [2:0]        out_status,
	output logic              out_err,
	output dnd_pkg::dnd_cmd_t cmd,
	input  dnd_pkg::dnd_sts_t sts,
	output logic              busy
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;  // check and read next length byte
	localparam logic [3:0] S_LEN  = 4'd2;  // classify length byte
	localparam logic [3:0] S_PLO  = 4'd3;  // read pointer low byte
	localparam logic [3:0] S_PJMP = 4'd4;  // hop check and jump
	localparam logic [3:0] S_CPRD = 4'd5;  // read one label byte
	localparam logic [3:0] S_CPWR = 4'd6;  // write label byte
	localparam logic [3:0] S_ORD  = 4'd7;  // read name bytes into word
	localparam logic [3:0] S_OWT  = 4'd8;  // wait last read
	localparam logic [3:0] S_OUT  = 4'd9;  // present word
	localparam logic [3:0] S_ERR  = 4'd10; // present error

	logic [3:0] state_q, state_d;
	logic [2:0] err_q, err_d;
	logic       last_q, last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			err_q   <= dnd_pkg::ST_OK;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
			last_q  <= last_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		err_d   = err_q;
		last_d  = last_q;
		cmd     = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_mode)
						dnd_pkg::MODE_CLEAR:  cmd.clear = 1'b1;
						dnd_pkg::MODE_APPEND: cmd.append = 1'b1;
						dnd_pkg::MODE_DECOMP: begin
							cmd.load_pos = 1'b1;
							state_d = S_RD;
						end
						default: ;
					endcase
				end
			end
			S_RD: begin
				if (sts.past_end) begin
					err_d = dnd_pkg::ST_PAST_END;
					state_d = S_ERR;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_LEN;
				end
			end
			S_LEN: begin
				priority if (sts.is_ptr) begin
					cmd.take_ptr_hi = 1'b1;
					state_d = S_PLO;
				end else if (sts.is_zero) begin
					if (sts.too_long_end) begin
						err_d = dnd_pkg::ST_TOO_LONG;
						state_d = S_ERR;
					end else begin
						cmd.term = 1'b1;
						cmd.out_start = 1'b1;
						cmd.out_load = 1'b1;
						state_d = S_ORD;
					end
				end else if (sts.is_bad) begin
					err_d = dnd_pkg::ST_BAD_TYPE;
					state_d = S_ERR;
				end else if (sts.too_long_lbl) begin
					err_d = dnd_pkg::ST_TOO_LONG;
					state_d = S_ERR;
				end else begin
					cmd.take_len = 1'b1;
					state_d = S_CPRD;
				end
			end
			S_PLO: begin
				if (sts.past_end) begin
					err_d = dnd_pkg::ST_PAST_END;
					state_d = S_ERR;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_PJMP;
				end
			end
			S_PJMP: begin
				if (sts.hops_over) begin
					err_d = dnd_pkg::ST_HOPS;
					state_d = S_ERR;
				end else begin
					cmd.jump = 1'b1;
					state_d = S_RD;
				end
			end
			S_CPRD: begin
				if (sts.lbl_done) begin
					state_d = S_RD;
				end else if (sts.past_end) begin
					err_d = dnd_pkg::ST_PAST_END;
					state_d = S_ERR;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_CPWR;
				end
			end
			S_CPWR: begin
				cmd.copy = 1'b1;
				state_d = S_CPRD;
			end
			S_ORD: begin
				priority if (sts.out_end) begin
					last_d = 1'b1;
					state_d = S_OWT;
				end else if (sts.out_word_full) begin
					last_d = 1'b0;
					state_d = S_OUT;
				end else if (!sts.out_rd_full) begin
					cmd.out_rd = 1'b1;
				end
				// else the last reads of a full word are still landing
			end
			S_OWT: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					cmd.out_load = 1'b1;
					state_d = last_q ? S_IDLE : S_ORD;
					if (last_q) begin
						last_d = 1'b0;
					end
				end
			end
			S_ERR: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid  = (state_q == S_OUT) || (state_q == S_ERR);
	assign out_last   = (state_q == S_ERR) || last_q;
	assign out_status = (state_q == S_ERR) ? err_q : dnd_pkg::ST_OK;
	assign out_err    = state_q == S_ERR;
	assign busy       = state_q != S_IDLE;
endmodule

// ===== hdl/dns_name_decompressor_unit.sv =====
// channel   direction  payload
// in_ch     sink       mode, data_byte, start_offset
// out_ch    source     name_word, byte_count, last, status
// cfg_ch    sink       max_pointer_hops
//
// decompress walks the message memory, one port: length bytes, label bytes and pointers
// in turn; then the name is read out as result words, the final one marked last, and
// output stalls hold each result word until it is taken
// reset: message length zero, hop limit 16; memories keep contents
// a stalled result holds the block; no new transaction until it is taken
`include "dns_name_decompressor_unit_defines.svh"

module dns_name_decompressor_unit #(
	parameter int MSG_DEPTH = dnd_pkg::MSG_DEPTH_DEF,
	parameter int NAME_MAX  = dnd_pkg::NAME_MAX_DEF
) (
	input logic  clk,
	input logic  arst_n,
	dnd_stream_if.sink   in_ch,
	dnd_stream_if.source out_ch,
	dnd_stream_if.sink   cfg_ch
);
	// in payload {mode[23:22], data_byte[21:14], start_offset[13:0]}
	// out payload {name_word[71:8], byte_count[7:4], last[3], status[2:0]}
	dnd_pkg::dnd_cmd_t cmd;
	dnd_pkg::dnd_sts_t sts;
	logic [7:0]  hops_q;
	logic [63:0] word;
	logic [3:0]  word_cnt;
	logic        last, err, busy;
	logic [2:0]  status;

	// hop limit register
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hops_q <= dnd_pkg::HOPS_RESET;
		end else if (cfg_ch.valid) begin
			hops_q <= cfg_ch.payload[7:0];
		end
	end

	dnd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.payload[23:22]),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_last(last), .out_status(status), .out_err(err),
		.cmd(cmd), .sts(sts), .busy(busy)
	);

	dnd_datapath #(.MSG_DEPTH(MSG_DEPTH), .NAME_MAX(NAME_MAX)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_byte(in_ch.payload[21:14]), .in_offset(in_ch.payload[13:0]),
		.max_hops(hops_q), .sts(sts), .word(word), .word_cnt(word_cnt)
	);

	assign out_ch.payload = {err ? 64'd0 : word, err ? 4'd0 : word_cnt, last, status};

	`DND_ASSERT_IMPL(a_busy_no_in, clk, arst_n, busy, !in_ch.ready, "input taken while busy")
	`DND_ASSERT_IMPL(a_ok_count, clk, arst_n, out_ch.valid && status == dnd_pkg::ST_OK,
		word_cnt != 4'd0 && word_cnt <= 4'd8, "ok result with bad byte count")
	`DND_ASSERT_IMPL(a_err_last, clk, arst_n, out_ch.valid && status != dnd_pkg::ST_OK,
		last, "error result not marked last")
	`DND_ASSERT_NEVER(a_one_cmd, clk, arst_n, cmd.copy && cmd.take_len, "copy and length together")
endmodule
